/* sv/kmcq_pkg.sv */
// ----------------------------------------------------------------------------
// kmcq_pkg
// Shared types, constants and code tables for the key code queue.
// ----------------------------------------------------------------------------
package kmcq_pkg;

    localparam int FIFO_DEPTH = 5;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SCAN_LIMIT = 72;

    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        SEL_ASCII   = 2'd0,
        SEL_MODS    = 2'd1,
        SEL_PETSCII = 2'd2,
        SEL_NONE    = 2'd3
    } t_sel;

    typedef enum logic [2:0] {
        TBL_BASE, TBL_SHIFT, TBL_CTRL, TBL_CBM, TBL_ALT
    } t_tbl;

    // per-cell control: push a code or shift toward the head
    typedef struct packed {
        logic       push;
        logic       pop;
        t_cnt       count;
        logic [7:0] code;
    } t_fifo_ctl;

    typedef logic [7:0] t_row [SCAN_LIMIT];

    localparam t_row ASC_BASE = '{8'h14,8'h0D,8'h1d,8'hf7,8'hf1,8'hf3,8'hf5,8'h11,8'h33,8'h77,
        8'h61,8'h34,8'h7a,8'h73,8'h65,8'h00,8'h35,8'h72,8'h64,8'h36,8'h63,8'h66,8'h74,8'h78,
        8'h37,8'h79,8'h67,8'h38,8'h62,8'h68,8'h75,8'h76,8'h39,8'h69,8'h6a,8'h30,8'h6d,8'h6b,
        8'h6f,8'h6e,8'h2b,8'h70,8'h6c,8'h2d,8'h2e,8'h3a,8'h40,8'h2c,8'ha3,8'h2a,8'h3b,8'h13,
        8'h00,8'h3d,8'hAF,8'h2f,8'h31,8'h5f,8'h00,8'h32,8'h20,8'h00,8'h71,8'h03,8'h00,8'h09,
        8'h00,8'h1f,8'hf9,8'hfb,8'hfd,8'h1b};
    localparam t_row ASC_SHIFT = '{8'h94,8'h0D,8'h9d,8'hf8,8'hf2,8'hf4,8'hf6,8'h91,8'h23,8'h57,
        8'h41,8'h24,8'h5a,8'h53,8'h45,8'h00,8'h25,8'h52,8'h44,8'h26,8'h43,8'h46,8'h54,8'h58,
        8'h27,8'h59,8'h47,8'h28,8'h42,8'h48,8'h55,8'h56,8'h29,8'h49,8'h4a,8'h7b,8'h4d,8'h4b,
        8'h4f,8'h4e,8'h00,8'h50,8'h4c,8'h00,8'h3e,8'h5b,8'h00,8'h3c,8'h00,8'h00,8'h5d,8'h93,
        8'h00,8'h5f,8'h00,8'h3f,8'h21,8'h60,8'h00,8'h22,8'h20,8'h00,8'h51,8'ha3,8'h00,8'h0f,
        8'h00,8'h1f,8'hfa,8'hfc,8'hfe,8'h1b};
    localparam t_row ASC_CTRL = '{8'h94,8'h0D,8'h9d,8'hf8,8'hf2,8'hf4,8'hf6,8'h91,8'h1c,8'h17,
        8'h01,8'h9f,8'h1a,8'h13,8'h05,8'h00,8'h9c,8'h12,8'h04,8'h1e,8'h03,8'h06,8'h14,8'h18,
        8'h1f,8'h19,8'h07,8'h9e,8'h02,8'h08,8'h15,8'h16,8'h12,8'h09,8'h0a,8'h00,8'h0d,8'h0b,
        8'h0f,8'h0e,8'h2b,8'h10,8'h0c,8'h2d,8'h2e,8'h3a,8'h40,8'h2c,8'h00,8'hEF,8'h3b,8'h93,
        8'h00,8'h3d,8'h00,8'h2f,8'h90,8'h60,8'h00,8'h05,8'h20,8'h00,8'h11,8'ha3,8'h00,8'h0f,
        8'h00,8'h1f,8'hfa,8'hfc,8'hfe,8'h1b};
    localparam t_row ASC_CBM = '{8'h94,8'h0D,8'hED,8'hf8,8'hf2,8'hf4,8'hf6,8'hEE,8'h96,8'hd7,
        8'hc1,8'h97,8'hda,8'hd3,8'hc5,8'h00,8'h98,8'hd2,8'hc4,8'h99,8'hc3,8'hc6,8'hd4,8'hd8,
        8'h9a,8'hd9,8'hc7,8'h9b,8'hc2,8'hc8,8'hd5,8'hd6,8'h92,8'hc9,8'hca,8'h81,8'hcd,8'hcb,
        8'hcf,8'hce,8'h2b,8'hd0,8'hcc,8'h2d,8'h7c,8'h7b,8'h40,8'h7e,8'h00,8'h2A,8'h7d,8'h93,
        8'h00,8'h5f,8'h00,8'h5c,8'h81,8'h60,8'h00,8'h95,8'h20,8'h00,8'hd1,8'ha3,8'h00,8'hef,
        8'h00,8'h1f,8'hfa,8'hfc,8'hfe,8'h1b};
    localparam t_row ASC_ALT = '{8'h7f,8'h00,8'hdf,8'hde,8'hB9,8'hB2,8'hB3,8'h00,8'hA4,8'hAE,
        8'hE5,8'hA2,8'hF7,8'hA7,8'hE6,8'h00,8'hB0,8'hAE,8'hF0,8'hA5,8'hE7,8'h00,8'hFE,8'hD7,
        8'hB4,8'hFF,8'hE8,8'hE2,8'hFA,8'hFD,8'hFC,8'hd3,8'hda,8'hED,8'hE9,8'hdb,8'hB5,8'hE1,
        8'hF8,8'hF1,8'hB1,8'hB6,8'hF3,8'hAC,8'hBB,8'hE4,8'hA8,8'hAB,8'hA3,8'hB7,8'hE4,8'hDC,
        8'hDD,8'hA6,8'hAF,8'hBF,8'hA1,8'hB8,8'h00,8'hAA,8'ha0,8'h00,8'hA9,8'hBA,8'h00,8'hC0,
        8'h00,8'h1f,8'hBC,8'hBD,8'hBE,8'hDB};
    localparam t_row PET_BASE = '{
        8'h14,8'h0d,8'h1d,8'h88,8'h85,8'h86,8'h87,8'h11,8'h33,8'h57,8'h41,8'h34,8'h5a,8'h53,
        8'h45,8'h01,8'h35,8'h52,8'h44,8'h36,8'h43,8'h46,8'h54,8'h58,8'h37,8'h59,8'h47,8'h38,
        8'h42,8'h48,8'h55,8'h56,8'h39,8'h49,8'h4a,8'h30,8'h4d,8'h4b,8'h4f,8'h4e,8'h2b,8'h50,
        8'h4c,8'h2d,8'h2e,8'h3a,8'h40,8'h2c,8'h5c,8'h2a,8'h3b,8'h13,8'h01,8'h3d,8'h5e,8'h2f,
        8'h31,8'h5f,8'h04,8'h32,8'h20,8'h02,8'h51,8'h03,8'hff,8'h09,8'h08,8'h84,8'h10,8'h16,
        8'h19,8'h1b};
    localparam t_row PET_SHIFT = '{
        8'h94,8'h8d,8'h9d,8'h8c,8'h89,8'h8a,8'h8b,8'h91,8'h23,8'hd7,8'hc1,8'h24,8'hda,8'hd3,
        8'hc5,8'h01,8'h25,8'hd2,8'hc4,8'h26,8'hc3,8'hc6,8'hd4,8'hd8,8'h27,8'hd9,8'hc7,8'h28,
        8'hc2,8'hc8,8'hd5,8'hd6,8'h29,8'hc9,8'hca,8'h30,8'hcd,8'hcb,8'hcf,8'hce,8'hdb,8'hd0,
        8'hcc,8'hdd,8'h3e,8'h5b,8'hba,8'h3c,8'ha9,8'hc0,8'h5d,8'h93,8'h01,8'h3d,8'hde,8'h3f,
        8'h21,8'h5f,8'h04,8'h22,8'ha0,8'h02,8'hd1,8'h83,8'hff,8'h1a,8'h08,8'h84,8'h15,8'h17,
        8'h1a,8'h1b};
    localparam t_row PET_CBM = '{
        8'h94,8'h8d,8'h9d,8'h8c,8'h89,8'h8a,8'h8b,8'h91,8'h96,8'hb3,8'hb0,8'h97,8'had,8'hae,
        8'hb1,8'h01,8'h98,8'hb2,8'hac,8'h99,8'hbc,8'hbb,8'ha3,8'hbd,8'h9a,8'hb7,8'ha5,8'h9b,
        8'hbf,8'hb4,8'hb8,8'hbe,8'h29,8'ha2,8'hb5,8'h30,8'ha7,8'ha1,8'hb9,8'haa,8'ha6,8'haf,
        8'hb6,8'hdc,8'h7c,8'h7b,8'ha4,8'h7e,8'ha8,8'hdf,8'h7d,8'h93,8'h01,8'h5f,8'hde,8'h5c,
        8'h81,8'h60,8'h04,8'h95,8'ha0,8'h02,8'hab,8'h03,8'hff,8'h18,8'h08,8'h84,8'h15,8'h17,
        8'h1a,8'h1b};
    localparam t_row PET_CTRL = '{
        8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h1c,8'h17,8'h01,8'h9f,8'h1a,8'h13,
        8'h05,8'hff,8'h9c,8'h12,8'h04,8'h1e,8'h03,8'h06,8'h14,8'h18,8'h1f,8'h19,8'h07,8'h9e,
        8'h02,8'h08,8'h15,8'h16,8'h12,8'h09,8'h0a,8'h92,8'h0d,8'h0b,8'h0f,8'h0e,8'hff,8'h10,
        8'h0c,8'hff,8'hff,8'h1b,8'h00,8'hff,8'h1c,8'hff,8'h1d,8'hff,8'hff,8'h1f,8'h1e,8'hff,
        8'h90,8'h60,8'hff,8'h05,8'hff,8'hff,8'h11,8'hff,8'hff,8'h09,8'h08,8'h84,8'hff,8'hff,
        8'hff,8'h1b};

    function automatic t_tbl ascii_tbl(input logic [4:0] sel);
        t_tbl t;
        if (sel == 5'd0)                       t = TBL_BASE;
        else if (sel < 5'd4)                   t = TBL_SHIFT;
        else if (sel < 5'd8)                   t = TBL_CTRL;
        else if (sel >= 5'd16 && sel < 5'd24)  t = TBL_ALT;
        else                                   t = TBL_CBM;
        return t;
    endfunction

    function automatic t_tbl petscii_tbl(input logic [3:0] sel);
        t_tbl t;
        if (sel == 4'd0)      t = TBL_BASE;
        else if (sel < 4'd4)  t = TBL_SHIFT;
        else if (sel < 4'd8)  t = TBL_CTRL;
        else                  t = TBL_CBM;
        return t;
    endfunction

endpackage

/* sv/kmcq_cell.sv */
// ----------------------------------------------------------------------------
// kmcq_cell
// One queue slot: loads a pushed code or takes its neighbor's code on a pop.
// ----------------------------------------------------------------------------
module kmcq_cell import kmcq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_ctl  i_ctl,
    input  t_cnt       i_index,
    input  logic [7:0] i_next,
    output logic [7:0] o_data
);
    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.pop) begin
            if (i_ctl.count > t_cnt'(1)) begin
                if (i_index < i_ctl.count - t_cnt'(1)) n_data = i_next;
            end else if (i_index == '0) begin
                n_data = '0;
            end
        end else if (i_ctl.push && i_index == i_ctl.count) begin
            n_data = i_ctl.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;
endmodule

/* sv/kmcq_queue.sv */
// ----------------------------------------------------------------------------
// kmcq_queue
// Shift queue built from a chain of cells, with a fill count; head at cell 0.
// ----------------------------------------------------------------------------
module kmcq_queue import kmcq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_pop,
    input  logic [7:0] i_code,
    output logic [7:0] o_head
);
    t_cnt       r_count;
    t_cnt       n_count;
    t_fifo_ctl  ctl;
    logic [7:0] cell_q [FIFO_DEPTH+1];

    assign ctl.push  = i_push && i_code != 8'h00 && r_count < t_cnt'(FIFO_DEPTH);
    assign ctl.pop   = i_pop;
    assign ctl.count = r_count;
    assign ctl.code  = i_code;
    assign cell_q[FIFO_DEPTH] = '0;

    genvar g;
    generate
        for (g = 0; g < FIFO_DEPTH; g++) begin : g_cell
            kmcq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_index (t_cnt'(g)),
                .i_next  (cell_q[g+1]),
                .o_data  (cell_q[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_pop) n_count = (r_count > t_cnt'(1)) ? r_count - t_cnt'(1) : '0;
        else if (ctl.push) n_count = r_count + t_cnt'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head = (r_count != '0) ? cell_q[0] : 8'h00;
endmodule

/* sv/keyboard_matrix_to_code_queue.sv */
// ----------------------------------------------------------------------------
// keyboard_matrix_to_code_queue
// Key events to ASCII and PETSCII code queues with register reads and pops.
// ----------------------------------------------------------------------------
// Items enter on i_start while o_busy is low; o_busy is always low, so one
// item may be taken every cycle. i_req_type selects a key event, a register
// read or a pop. A key press looks up both code tables in the accept cycle
// and pushes into the two cell-chain queues at that edge. A read returns
// o_read_data with o_done high for one cycle, in the cycle after acceptance,
// from the state the item saw. Key events and pops give no result. The
// receiver cannot stall; results are never held. Synchronous reset empties
// both queues, clears the modifiers and sets selector_enable. The APB port
// holds selector_enable at address 0; pready is always high, no wait states.
// ----------------------------------------------------------------------------
module keyboard_matrix_to_code_queue import kmcq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_key_pos,
    input  logic        i_key_pressed,
    input  logic [5:0]  i_key_modifiers,
    input  logic [1:0]  i_reg_select,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic       r_sel_en;
    logic [5:0] r_mods;
    logic       r_done;
    logic [7:0] r_data;
    logic [7:0] n_data;
    logic [6:0] scan;
    logic       scan_ok;
    logic [7:0] asc_code;
    logic [7:0] pet_code;
    logic [7:0] asc_head;
    logic [7:0] pet_head;
    logic       is_key;
    logic       do_press;
    logic       pop_a;
    logic       pop_p;
    t_tbl       atbl;
    t_tbl       ptbl;
    t_req       req;
    t_sel       sel;

    assign o_busy = 1'b0;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_sel_en};
    assign req    = t_req'(i_req_type);
    assign sel    = t_sel'(i_reg_select);
    assign is_key = i_start && req == REQ_KEY;

    // modifiers in force for this press are the ones it carries
    assign scan     = {i_key_pos[7:4], i_key_pos[2:0]};
    assign scan_ok  = scan < 7'(SCAN_LIMIT);
    assign do_press = is_key && i_key_pressed && scan_ok;
    assign atbl     = ascii_tbl(r_sel_en ? i_key_modifiers[4:0] : 5'd0);
    assign ptbl     = petscii_tbl(i_key_modifiers[3:0]);

    always_comb begin
        asc_code = 8'h00;
        pet_code = 8'h00;
        if (scan_ok) begin
            unique case (atbl)
                TBL_BASE:  asc_code = ASC_BASE[scan];
                TBL_SHIFT: asc_code = ASC_SHIFT[scan];
                TBL_CTRL:  asc_code = ASC_CTRL[scan];
                TBL_CBM:   asc_code = ASC_CBM[scan];
                TBL_ALT:   asc_code = ASC_ALT[scan];
                default:   asc_code = 8'h00;
            endcase
            unique case (ptbl)
                TBL_BASE:  pet_code = PET_BASE[scan];
                TBL_SHIFT: pet_code = PET_SHIFT[scan];
                TBL_CTRL:  pet_code = PET_CTRL[scan];
                TBL_CBM:   pet_code = PET_CBM[scan];
                default:   pet_code = 8'h00;
            endcase
        end
    end

    assign pop_a = i_start && req == REQ_WRITE && sel == SEL_ASCII;
    assign pop_p = i_start && req == REQ_WRITE && sel == SEL_PETSCII;

    kmcq_queue u_ascii (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (do_press),
        .i_pop   (pop_a),
        .i_code  (asc_code),
        .o_head  (asc_head)
    );

    kmcq_queue u_petscii (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (do_press && pet_code != 8'hFF),
        .i_pop   (pop_p),
        .i_code  (pet_code),
        .o_head  (pet_head)
    );

    always_comb begin
        unique case (sel)
            SEL_ASCII:   n_data = asc_head;
            SEL_MODS:    n_data = {~r_sel_en, 1'b0, r_mods};
            SEL_PETSCII: n_data = pet_head;
            default:     n_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_en <= 1'b1;
            r_mods   <= '0;
            r_done   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) r_sel_en <= pwdata[0];
            if (is_key) r_mods <= i_key_modifiers;
            r_done <= i_start && req == REQ_READ;
        end
        r_data <= n_data;
    end

    assign o_done      = r_done;
    assign o_read_data = r_data;
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Key code queue bench: key events, register reads and pops against a local
// model of both code queues, with selector_enable changed between phases.
// ----------------------------------------------------------------------------
module tb;
    import kmcq_pkg::*;

    typedef struct packed {
        t_req       req;
        logic [7:0] pos;
        logic       pressed;
        logic [5:0] mods;
        t_sel       sel;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_key_pos = '0;
    logic        i_key_pressed = 1'b0;
    logic [5:0]  i_key_modifiers = '0;
    logic [1:0]  i_reg_select = '0;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    keyboard_matrix_to_code_queue dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // model state
    logic [7:0] asc_q [$];
    logic [7:0] pet_q [$];
    logic [5:0] mod_bits;
    logic       sel_en;
    logic [7:0] read_exp [$];
    t_item      pending [$];
    int         errors = 0;
    int         reads_seen = 0;
    int         idle_cycles = 0;
    int         gap = 0;
    int         burst = 0;
    int         pushes_dropped = 0;

    function automatic logic [7:0] ascii_code(logic [4:0] s, logic [6:0] k);
        if (s == 0) return ASC_BASE[k];
        if (s < 4) return ASC_SHIFT[k];
        if (s < 8) return ASC_CTRL[k];
        if (s >= 16 && s < 24) return ASC_ALT[k];
        return ASC_CBM[k];
    endfunction

    function automatic logic [7:0] petscii_code(logic [3:0] s, logic [6:0] k);
        if (s == 0) return PET_BASE[k];
        if (s < 4) return PET_SHIFT[k];
        if (s < 8) return PET_CTRL[k];
        return PET_CBM[k];
    endfunction

    task automatic apply_item(input t_item it);
        logic [7:0] scan;
        logic [7:0] c;
        scan = {1'b0, it.pos[7:4], 3'b000} | {5'b0, it.pos[2:0]};
        case (it.req)
            REQ_KEY: begin
                mod_bits = it.mods;
                if (it.pressed && scan < SCAN_LIMIT) begin
                    c = ascii_code(sel_en ? mod_bits[4:0] : 5'd0, scan[6:0]);
                    if (c != 0) begin
                        if (asc_q.size() < FIFO_DEPTH) asc_q.push_back(c);
                        else pushes_dropped++;
                    end
                    c = petscii_code(mod_bits[3:0], scan[6:0]);
                    if (c != 0 && c != 8'hFF) begin
                        if (pet_q.size() < FIFO_DEPTH) pet_q.push_back(c);
                        else pushes_dropped++;
                    end
                end
            end
            REQ_WRITE: begin
                if (it.sel == SEL_ASCII && asc_q.size() > 0) void'(asc_q.pop_front());
                else if (it.sel == SEL_PETSCII && pet_q.size() > 0)
                    void'(pet_q.pop_front());
            end
            REQ_READ: begin
                case (it.sel)
                    SEL_ASCII:   c = asc_q.size() ? asc_q[0] : 8'h00;
                    SEL_MODS:    c = {~sel_en, 1'b0, mod_bits};
                    SEL_PETSCII: c = pet_q.size() ? pet_q[0] : 8'h00;
                    default:     c = 8'h00;
                endcase
                read_exp.push_back(c);
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) apply_item(pending.pop_front());
            if (gap > 0) begin
                gap <= gap - 1;
                i_start <= 1'b0;
            end else if (pending.size() > 0 && !(i_start && !o_busy && pending.size() == 0))
            begin
                i_start <= 1'b1;
                i_req_type <= pending[0].req;
                i_key_pos <= pending[0].pos;
                i_key_pressed <= pending[0].pressed;
                i_key_modifiers <= pending[0].mods;
                i_reg_select <= pending[0].sel;
                if (burst <= 1) begin
                    burst <= $urandom_range(1, 20);
                    gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst <= burst - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                reads_seen++;
                if (read_exp.size() == 0) begin
                    $display("%0t: unexpected read data, expected none, actual %02h",
                             $realtime, o_read_data);
                    errors++;
                end else begin
                    if (o_read_data !== read_exp[0]) begin
                        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                                 $realtime, read_exp[0], o_read_data);
                        errors++;
                    end
                    void'(read_exp.pop_front());
                end
            end
            if (o_done || (i_start && !o_busy)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic t_item mk(t_req r, logic [7:0] p, logic k, logic [5:0] m, t_sel s);
        t_item it;
        it.req = r; it.pos = p; it.pressed = k; it.mods = m; it.sel = s;
        return it;
    endfunction

    function automatic logic [7:0] rand_pos();
        // mostly valid scan indices, some out of range
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return {4'($urandom_range(0, 8)), 1'($urandom), 3'($urandom)};
    endfunction

    task automatic add_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                pending.push_back(mk(REQ_KEY, rand_pos(), $urandom_range(0, 3) != 0,
                                     6'($urandom), t_sel'($urandom)));
            else if (r < 75)
                pending.push_back(mk(REQ_READ, 8'($urandom), 1'($urandom), 6'($urandom),
                                     t_sel'($urandom_range(0, 3))));
            else if (r < 97)
                pending.push_back(mk(REQ_WRITE, 8'($urandom), 1'($urandom), 6'($urandom),
                                     t_sel'($urandom_range(0, 3))));
            else
                pending.push_back(mk(REQ_NONE, 8'($urandom), 1'($urandom), 6'($urandom),
                                     t_sel'($urandom)));
        end
    endtask

    task automatic wait_drained();
        while (pending.size() > 0 || i_start || read_exp.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= v; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sel_en = v[0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        sel_en = 1'b1;
        mod_bits = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty reads/pops, table selections, overflow, out-of-range
        pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_ASCII));
        pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_PETSCII));
        pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_ASCII));
        pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_PETSCII));
        pending.push_back(mk(REQ_KEY, 8'h00, 1'b1, 6'h00, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h8F, 1'b1, 6'h01, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h12, 1'b1, 6'h04, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h17, 1'b1, 6'h08, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h20, 1'b1, 6'h10, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h40, 1'b1, 6'h18, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'hFF, 1'b1, 6'h3F, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h90, 1'b1, 6'h00, SEL_ASCII));
        pending.push_back(mk(REQ_KEY, 8'h55, 1'b0, 6'h2A, SEL_NONE));
        pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_MODS));
        pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_NONE));
        pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_MODS));
        pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_NONE));
        pending.push_back(mk(REQ_NONE, 8'hFF, 1'b1, 6'h3F, SEL_NONE));
        for (int i = 0; i < 3; i++) begin
            pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_ASCII));
            pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_PETSCII));
            pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_ASCII));
            pending.push_back(mk(REQ_WRITE, 8'h00, 1'b0, 6'h00, SEL_PETSCII));
        end
        wait_drained();
        add_random(130);
        wait_drained();
        apb_write(32'h0);
        pending.push_back(mk(REQ_READ, 8'h00, 1'b0, 6'h00, SEL_MODS));
        add_random(130);
        wait_drained();
        apb_write(32'hFFFF_FFFF);
        add_random(140);
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered key presses over all tables, reads, pops and both selector");
        $display("settings; %0d reads checked, %0d pushes dropped on full queues.",
                 reads_seen, pushes_dropped);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
